// File: src/decimal_digit_display_writer_assert.svh
// Assertion macros for the decimal digit display writer.
// Used by the top level; depends on nothing else.
`ifndef DECIMAL_DIGIT_DISPLAY_WRITER_ASSERT_SVH
`define DECIMAL_DIGIT_DISPLAY_WRITER_ASSERT_SVH

// Same-cycle implication, checked at every rising clock edge out of reset.
`define DDW_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("digit display writer check failed");

// Next-cycle implication.
`define DDW_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("digit display writer check failed");

`endif

// File: src/ddw_pkg.sv
// Shared types and constants of the decimal digit display writer.
// Used by the front, the queue, the back and the top level.
package ddw_pkg;

   localparam logic [7:0]  ASCII_ZERO = 8'h30;
   localparam logic [7:0]  BLANK_CODE = 8'd15;
   localparam logic [31:0] RECIP_TEN  = 32'hCCCC_CCCD;  // ceil(2^35 / 10)
   localparam int unsigned RECIP_SHIFT = 35;

   // One classified item handed from the front to the back.
   typedef struct packed {
      logic        err;
      logic [30:0] mag;
   } ddw_item_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_DIGITS,
      BK_ERROR
   } ddw_back_state_type;

endpackage

// File: src/ddw_front.sv
// Front part: accepts an input item and classifies it as displayable or error.
// Depends on ddw_pkg.
module ddw_front import ddw_pkg::*; #(
   parameter int DIGITS = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_value,
   output logic               push_valid,
   input  logic               push_ready,
   output ddw_item_type       push_item
);

   function automatic logic [63:0] pow10(input int n);
      logic [63:0] p;
      p = 64'd1;
      for (int i = 0; i < n; i++) begin
         p = p * 64'd10;
      end
      return p;
   endfunction

   localparam logic [63:0] LIMIT = pow10(DIGITS);

   logic         valid_ff, valid_in;
   ddw_item_type item_ff, item_in;
   logic         take;

   assign req_ready  = !valid_ff || push_ready;
   assign take       = req_valid && req_ready;
   assign push_valid = valid_ff;
   assign push_item  = item_ff;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (push_ready) begin
         valid_in = 1'b0;
      end
      // A negative value or one with more digits than the display holds is an error.
      item_in.err = req_value[31] || ({32'd0, req_value} >= LIMIT);
      item_in.mag = req_value[30:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (take) begin
         item_ff <= item_in;
      end
   end

endmodule

// File: src/ddw_queue.sv
// Two-entry queue that decouples the front from the back.
// Depends on ddw_pkg.
module ddw_queue import ddw_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push_valid,
   output logic         push_ready,
   input  ddw_item_type push_item,
   output logic         pop_valid,
   input  logic         pop_ready,
   output ddw_item_type pop_item
);

   ddw_item_type mem_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;
   logic         push, pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_item   = mem_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// File: src/ddw_back.sv
// Back part: peels off one decimal digit per cycle while the result register is free, and drives it.
// Depends on ddw_pkg.
module ddw_back import ddw_pkg::*; #(
   parameter int DIGITS = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         pop_valid,
   output logic         pop_ready,
   input  ddw_item_type pop_item,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output logic [3:0]   rsp_digit_address,
   output logic [7:0]   rsp_digit_code,
   output logic         rsp_is_write,
   output logic         rsp_status,
   output logic         rsp_last
);

   localparam int IW = (DIGITS > 1) ? $clog2(DIGITS) : 1;
   localparam logic [IW-1:0] LAST_IDX = IW'(DIGITS - 1);

   ddw_back_state_type state_ff, state_in;
   logic [30:0]   rest_ff, rest_in;
   logic [IW-1:0] idx_ff, idx_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [3:0]  addr_ff, addr_in;
   logic [7:0]  code_ff, code_in;
   logic        write_ff, write_in;
   logic        status_ff, status_in;
   logic        last_ff, last_in;

   logic        out_free, step, load;
   logic [62:0] prod;
   logic [30:0] quot, quot10;
   logic [30:0] remd;
   logic [4:0]  addr_sum;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign step     = (state_ff != BK_IDLE) && out_free;
   assign load     = pop_valid && pop_ready;

   // Divide by ten through a reciprocal multiply; exact for values below 2^32.
   assign prod     = {32'd0, rest_ff} * {31'd0, RECIP_TEN};
   assign quot     = {3'd0, prod[62:RECIP_SHIFT]};
   assign quot10   = {quot[27:0], 3'd0} + {quot[29:0], 1'b0};
   assign remd     = rest_ff - quot10;
   assign addr_sum = 5'(idx_ff) + 5'd1;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (pop_valid) begin
               state_in = pop_item.err ? BK_ERROR : BK_DIGITS;
            end
         end
         BK_DIGITS: begin
            if (step && (idx_ff == LAST_IDX)) begin
               state_in = BK_IDLE;
            end
         end
         BK_ERROR: begin
            if (step) begin
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_comb begin
      pop_ready    = (state_ff == BK_IDLE);
      rest_in      = rest_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      addr_in      = addr_ff;
      code_in      = code_ff;
      write_in     = write_ff;
      status_in    = status_ff;
      last_in      = last_ff;
      case (state_ff)
         BK_IDLE: begin
            if (load) begin
               rest_in = pop_item.mag;
               idx_in  = '0;
            end
         end
         BK_DIGITS: begin
            if (step) begin
               rsp_valid_in = 1'b1;
               addr_in      = addr_sum[3:0];
               // The first position always shows a digit, so zero reads as '0'.
               if ((idx_ff == '0) || (rest_ff != 31'd0)) begin
                  code_in = ASCII_ZERO + {4'd0, remd[3:0]};
               end else begin
                  code_in = BLANK_CODE;
               end
               write_in  = 1'b1;
               status_in = 1'b0;
               last_in   = (idx_ff == LAST_IDX);
               rest_in   = quot;
               idx_in    = idx_ff + 1'b1;
            end
         end
         BK_ERROR: begin
            if (step) begin
               rsp_valid_in = 1'b1;
               addr_in      = 4'd0;
               code_in      = 8'd0;
               write_in     = 1'b0;
               status_in    = 1'b1;
               last_in      = 1'b1;
            end
         end
         default: begin
            pop_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rest_ff   <= rest_in;
      idx_ff    <= idx_in;
      addr_ff   <= addr_in;
      code_ff   <= code_in;
      write_ff  <= write_in;
      status_ff <= status_in;
      last_ff   <= last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_digit_address = addr_ff;
   assign rsp_digit_code    = code_ff;
   assign rsp_is_write      = write_ff;
   assign rsp_status        = status_ff;
   assign rsp_last          = last_ff;

endmodule

// File: src/decimal_digit_display_writer.sv
// Decimal digit display writer: a signed 32-bit value in, DIGITS digit register
// writes out (register 1 is least significant, ASCII digits then blank code 15), or
// a single error result when the value is negative or has more than DIGITS digits.
// The back sequencer divides by ten once per cycle through a reciprocal
// multiplier and emits one digit write per cycle while the result register is
// free. A two-entry queue behind the input stage lets new values be accepted
// while results are streaming.
// Top level; depends on ddw_pkg, ddw_front, ddw_queue, ddw_back and the assert header.
module decimal_digit_display_writer import ddw_pkg::*; #(
   parameter int DIGITS = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [3:0]         rsp_digit_address,
   output logic [7:0]         rsp_digit_code,
   output logic               rsp_is_write,
   output logic               rsp_status,
   output logic               rsp_last
);

`include "decimal_digit_display_writer_assert.svh"

   logic         push_valid, push_ready;
   ddw_item_type push_item;
   logic         pop_valid, pop_ready;
   ddw_item_type pop_item;

   ddw_front #(.DIGITS(DIGITS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_value  (req_value),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item)
   );

   ddw_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   ddw_back #(.DIGITS(DIGITS)) u_back (
      .clock             (clock),
      .reset             (reset),
      .pop_valid         (pop_valid),
      .pop_ready         (pop_ready),
      .pop_item          (pop_item),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_digit_address (rsp_digit_address),
      .rsp_digit_code    (rsp_digit_code),
      .rsp_is_write      (rsp_is_write),
      .rsp_status        (rsp_status),
      .rsp_last          (rsp_last)
   );

   // Digit writes never carry an error status.
   `DDW_ASSERT_NOW(a_write_ok, rsp_valid && rsp_is_write, !rsp_status)
   // An error result stands alone at address zero.
   `DDW_ASSERT_NOW(a_error_form, rsp_valid && !rsp_is_write,
                   rsp_last && rsp_status && (rsp_digit_address == 4'd0))
   // A non-blank digit code is always an ASCII decimal digit.
   `DDW_ASSERT_NOW(a_digit_code, rsp_valid && rsp_is_write && (rsp_digit_code != BLANK_CODE),
                   (rsp_digit_code >= 8'h30) && (rsp_digit_code <= 8'h39))
   // The writes of one value follow each other without gaps.
   `DDW_ASSERT_NEXT(a_no_gap, rsp_valid && rsp_ready && !rsp_last, rsp_valid)

endmodule
